// ----- hdl/drtc_pkg.sv -----
// ----------------------------------------------------------------------------
// drtc_pkg
// shared constants and types for the dump region table checker
// ----------------------------------------------------------------------------
`default_nettype none

package drtc_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ENTRY_AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;

  localparam logic [15:0] READ_LIMIT_RESET = 16'd248;

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_METADATA = 3'd2;
  localparam logic [2:0] OP_ENTRY    = 3'd3;
  localparam logic [2:0] OP_RDCHECK  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              lt;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/drtc_ram.sv -----
// ----------------------------------------------------------------------------
// drtc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module drtc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/drtc_alu.sv -----
// ----------------------------------------------------------------------------
// drtc_alu
// shared 32-bit adder and unsigned less-than compare
// ----------------------------------------------------------------------------
`default_nettype none

module drtc_alu (
  input  wire drtc_pkg::alu_req_t req,
  output drtc_pkg::alu_rsp_t      rsp
);

  always_comb begin
    rsp.sum = req.add_a + req.add_b;
    rsp.lt  = (req.cmp_a < req.cmp_b);
  end

endmodule

`default_nettype wire

// ----- hdl/dump_region_table_checker.sv -----
// ----------------------------------------------------------------------------
// dump_region_table_checker
// region table with register, clear, metadata, entry info and read window
// check requests, sequenced over one shared adder and compare unit
//
//   channel   signals                                  direction
//   in        in_valid, in_stall, operation, entry_index,
//             region_address, region_size              request in
//   out       out_valid, out_stall, status, entry_count, total_size,
//             entry_address, entry_size, read_length   result out
//   config    write_enable, write_data                 read limit write
//
// register, clear, metadata, unknown ops: accept, emit; entry info adds a check
// read check: accept, check, E1 to E4, emit, five of them on the shared unit
// the table ram is read once per request, at accept; its contents are not reset
// in_stall is high while a request is in flight
// a finished result waits in the emit step until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module dump_region_table_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] entry_index,
  input  wire logic [31:0] region_address,
  input  wire logic [31:0] region_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [6:0]       entry_count,
  output logic [31:0]      total_size,
  output logic [31:0]      entry_address,
  output logic [31:0]      entry_size,
  output logic [31:0]      read_length,
  input  wire logic        write_enable,
  input  wire logic [15:0] write_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_E1   = 3'd2;
  localparam logic [2:0] S_E2   = 3'd3;
  localparam logic [2:0] S_E3   = 3'd4;
  localparam logic [2:0] S_E4   = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam int AW = drtc_pkg::ENTRY_AW;
  localparam int CW = drtc_pkg::COUNT_W;
  localparam int DW = drtc_pkg::DATA_W;

  logic [2:0]    state;
  logic [CW-1:0] used_entries;
  logic [DW-1:0] size_total;
  logic [15:0]   read_limit;

  logic [2:0]    req_op;
  logic [15:0]   req_index;
  logic [DW-1:0] req_address;
  logic [DW-1:0] req_size;
  logic [DW-1:0] entry_end;
  logic [DW-1:0] window_end;
  logic          window_fail;
  logic          clip;

  logic [1:0]    res_status;
  logic [6:0]    res_count;
  logic [DW-1:0] res_total;
  logic [DW-1:0] res_address;
  logic [DW-1:0] res_size;
  logic [DW-1:0] res_length;

  logic              accept;
  logic              full;
  logic              out_free;
  logic              ram_we;
  logic [2*DW-1:0]   ram_rdata;
  logic [DW-1:0]     tbl_start;
  logic [DW-1:0]     tbl_size;
  drtc_pkg::alu_req_t alu_req;
  drtc_pkg::alu_rsp_t alu_rsp;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (used_entries == CW'(drtc_pkg::MAX_ENTRIES));
  assign out_free  = !out_valid || !out_stall;
  assign ram_we    = accept && (operation == drtc_pkg::OP_REGISTER) && !full;
  assign tbl_start = ram_rdata[2*DW-1:DW];
  assign tbl_size  = ram_rdata[DW-1:0];

  drtc_ram #(
    .WIDTH(2 * drtc_pkg::DATA_W),
    .DEPTH(drtc_pkg::MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(used_entries[AW-1:0]),
    .wdata({region_address, region_size}),
    .re   (accept),
    .raddr(entry_index[AW-1:0]),
    .rdata(ram_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    alu_req = '0;
    case (state)
      S_IDLE: begin
        alu_req.add_a = size_total;
        alu_req.add_b = region_size;
      end
      S_CHK: begin
        alu_req.cmp_a = DW'(req_index);
        alu_req.cmp_b = DW'(used_entries);
      end
      S_E1: begin
        alu_req.add_a = tbl_start;
        alu_req.add_b = tbl_size;
        alu_req.cmp_a = req_address;
        alu_req.cmp_b = tbl_start;
      end
      S_E2: begin
        alu_req.add_a = req_address;
        alu_req.add_b = req_size;
        alu_req.cmp_a = req_size;
        alu_req.cmp_b = DW'(read_limit);
      end
      S_E3: begin
        alu_req.cmp_a = entry_end;
        alu_req.cmp_b = window_end;
      end
      S_E4: begin
        alu_req.cmp_a = window_end;
        alu_req.cmp_b = req_address;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  drtc_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      used_entries <= '0;
      size_total   <= '0;
      read_limit   <= drtc_pkg::READ_LIMIT_RESET;
    end else begin
      if (write_enable) begin
        read_limit <= write_data;
      end
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_op      <= operation;
            req_index   <= entry_index;
            req_address <= region_address;
            req_size    <= region_size;
            window_fail <= 1'b0;
            res_status  <= (operation == drtc_pkg::OP_REGISTER && full) ?
                           drtc_pkg::ST_OVERFLOW :
                           (operation > drtc_pkg::OP_RDCHECK) ?
                           drtc_pkg::ST_INVALID : drtc_pkg::ST_OK;
            res_count   <= (operation == drtc_pkg::OP_METADATA) ? 7'(used_entries) : '0;
            res_total   <= (operation == drtc_pkg::OP_METADATA) ? size_total : '0;
            res_address <= '0;
            res_size    <= '0;
            res_length  <= '0;
            case (operation)
              drtc_pkg::OP_REGISTER: begin
                if (!full) begin
                  used_entries <= used_entries + CW'(1);
                  size_total   <= alu_rsp.sum;
                end
                state <= S_EMIT;
              end
              drtc_pkg::OP_CLEAR: begin
                used_entries <= '0;
                size_total   <= '0;
                state        <= S_EMIT;
              end
              drtc_pkg::OP_METADATA: begin
                state <= S_EMIT;
              end
              drtc_pkg::OP_ENTRY, drtc_pkg::OP_RDCHECK: begin
                state <= S_CHK;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_CHK: begin
          if (!alu_rsp.lt) begin
            res_status <= drtc_pkg::ST_INVALID;
            state      <= S_EMIT;
          end else if (req_op == drtc_pkg::OP_ENTRY) begin
            res_address <= tbl_start;
            res_size    <= tbl_size;
            state       <= S_EMIT;
          end else begin
            state <= S_E1;
          end
        end
        S_E1: begin
          entry_end   <= alu_rsp.sum;
          window_fail <= alu_rsp.lt;
          state       <= S_E2;
        end
        S_E2: begin
          window_end <= alu_rsp.sum;
          clip       <= alu_rsp.lt;
          state      <= S_E3;
        end
        S_E3: begin
          if (alu_rsp.lt) begin
            window_fail <= 1'b1;
          end
          state <= S_E4;
        end
        S_E4: begin
          if (window_fail || alu_rsp.lt) begin
            res_status <= drtc_pkg::ST_INVALID;
          end else begin
            res_length <= clip ? req_size : DW'(read_limit);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            status        <= res_status;
            entry_count   <= res_count;
            total_size    <= res_total;
            entry_address <= res_address;
            entry_size    <= res_size;
            read_length   <= res_length;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_entries <= CW'(drtc_pkg::MAX_ENTRIES))
    else $error("entry count above table depth");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("request taken while busy");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> out_valid)
    else $error("result not loaded from emit step");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !full)
    else $error("table write while full");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == drtc_pkg::OP_CLEAR) |=> (used_entries == '0 && size_total == '0))
    else $error("clear left table state");

endmodule

`default_nettype wire

// ----- bench/drtc_result_monitor.sv -----
// ----------------------------------------------------------------------------
// drtc_result_monitor
// watches both channels and the read limit port of the region table checker,
// keeps its own copy of the region table, predicts one result per accepted
// request and compares every accepted result field by field in order
// ----------------------------------------------------------------------------
module drtc_result_monitor
  import drtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [15:0] entry_index,
  input  logic [31:0] region_address,
  input  logic [31:0] region_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [6:0]  entry_count,
  input  logic [31:0] total_size,
  input  logic [31:0] entry_address,
  input  logic [31:0] entry_size,
  input  logic [31:0] read_length,
  input  logic        write_enable,
  input  logic [15:0] write_data,
  output int          results_owed,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] total;
    logic [31:0] start_addr;
    logic [31:0] bytes;
    logic [31:0] rd_len;
  } region_result_t;

  logic [31:0]    region_start [MAX_ENTRIES];
  logic [31:0]    region_bytes [MAX_ENTRIES];
  int             entries_used;
  logic [31:0]    bytes_total;
  logic [15:0]    limit_bytes;
  region_result_t expected_results [$];

  function automatic region_result_t table_outcome(input logic [2:0] op,
                                                   input logic [15:0] idx,
                                                   input logic [31:0] addr,
                                                   input logic [31:0] size);
    region_result_t r;
    logic [31:0] e_end;
    logic [31:0] w_end;
    r = '0;
    case (op)
      OP_REGISTER: begin
        if (entries_used >= MAX_ENTRIES) begin
          r.status = ST_OVERFLOW;
        end else begin
          region_start[entries_used] = addr;
          region_bytes[entries_used] = size;
          entries_used++;
          bytes_total += size;
          r.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        foreach (region_start[i]) begin
          region_start[i] = '0;
          region_bytes[i] = '0;
        end
        entries_used = 0;
        bytes_total = '0;
        r.status = ST_OK;
      end
      OP_METADATA: begin
        r.status = ST_OK;
        r.count = 7'(entries_used);
        r.total = bytes_total;
      end
      OP_ENTRY: begin
        if (int'(idx) >= entries_used) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_OK;
          r.start_addr = region_start[idx];
          r.bytes = region_bytes[idx];
        end
      end
      OP_RDCHECK: begin
        if (int'(idx) >= entries_used) begin
          r.status = ST_INVALID;
        end else begin
          e_end = region_start[idx] + region_bytes[idx];
          w_end = addr + size;
          if (addr < region_start[idx] || e_end < w_end || w_end < addr) begin
            r.status = ST_INVALID;
          end else begin
            r.status = ST_OK;
            r.rd_len = (size < {16'd0, limit_bytes}) ? size : {16'd0, limit_bytes};
          end
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    region_result_t want;
    if (rst) begin
      foreach (region_start[i]) begin
        region_start[i] = '0;
        region_bytes[i] = '0;
      end
      entries_used = 0;
      bytes_total = '0;
      limit_bytes = READ_LIMIT_RESET;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (write_enable) begin
        limit_bytes = write_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("entry_count", 32'(want.count), 32'(entry_count));
          check_field("total_size", want.total, total_size);
          check_field("entry_address", want.start_addr, entry_address);
          check_field("entry_size", want.bytes, entry_size);
          check_field("read_length", want.rd_len, read_length);
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(table_outcome(operation, entry_index,
                                                 region_address, region_size));
      end
    end
    results_owed = expected_results.size();
  end

endmodule

// ----- bench/tb_dump_region_table_checker.sv -----
// ----------------------------------------------------------------------------
// tb_dump_region_table_checker
// drives register, clear, metadata, entry info, read window and unknown op requests into
// the region table checker with random gaps and output stalls, changes the
// read limit between phases while idle, and reports the monitor's verdict
// ----------------------------------------------------------------------------
module tb_dump_region_table_checker;
  import drtc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [15:0] entry_index = '0;
  logic [31:0] region_address = '0;
  logic [31:0] region_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic [31:0] total_size;
  logic [31:0] entry_address;
  logic [31:0] entry_size;
  logic [31:0] read_length;
  logic        write_enable = 1'b0;
  logic [15:0] write_data = '0;

  int          results_owed;
  int          mismatches;
  int          sent = 0;
  int          stuck_cycles = 0;
  bit          quiet = 1'b0;
  logic [31:0] shadow_start [MAX_ENTRIES];
  logic [31:0] shadow_bytes [MAX_ENTRIES];
  int          shadow_used = 0;

  always #2ns clk = ~clk;

  dump_region_table_checker i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .entry_index    (entry_index),
    .region_address (region_address),
    .region_size    (region_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .entry_count    (entry_count),
    .total_size     (total_size),
    .entry_address  (entry_address),
    .entry_size     (entry_size),
    .read_length    (read_length),
    .write_enable   (write_enable),
    .write_data     (write_data)
  );

  drtc_result_monitor i_monitor (.*);

  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < 21);
  end

  // no request and no result moving for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= 1000) begin
        $display("FAIL dump_region_table_checker");
        $finish;
      end
    end
  end

  function automatic longint unsigned rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(3))
      0: return $urandom_range(64);
      1: return $urandom_range(4096);
      2: return $urandom_range(300000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_address();
    if ($urandom_range(3) == 0) begin
      return 32'hFFFF_FFFF - $urandom_range(4096);
    end
    return $urandom;
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [15:0] idx,
                              input logic [31:0] addr, input logic [31:0] size);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 21) begin
      gap = $urandom_range(4, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    entry_index <= idx;
    region_address <= addr;
    region_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic add_region(input logic [31:0] addr, input logic [31:0] size);
    send_request(OP_REGISTER, 16'($urandom), addr, size);
    if (shadow_used < MAX_ENTRIES) begin
      shadow_start[shadow_used] = addr;
      shadow_bytes[shadow_used] = size;
      shadow_used++;
    end
  endtask

  task automatic clear_table();
    send_request(OP_CLEAR, 16'($urandom), $urandom, $urandom);
    shadow_used = 0;
  endtask

  // window inside entry k, optionally pushed one byte over an edge
  task automatic probe_window(input int k, input bit bend);
    longint unsigned off;
    longint unsigned span;
    longint unsigned len;
    logic [31:0]     addr;
    logic [31:0]     size;
    off = rnd64() % ({32'd0, shadow_bytes[k]} + 64'd1);
    span = {32'd0, shadow_bytes[k]} - off;
    if ($urandom_range(1)) begin
      len = rnd64() % (span + 64'd1);
    end else begin
      len = $urandom_range(300);
      if (len > span) len = span;
    end
    addr = shadow_start[k] + off[31:0];
    size = len[31:0];
    if (bend) begin
      case ($urandom_range(2))
        0: addr = addr - 1;
        1: size = size + 1;
        default: addr = addr + 1;
      endcase
    end
    send_request(OP_RDCHECK, 16'(k), addr, size);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] limit_plan [6];
    int          phase;
    int          pick;
    int          k;
    int          n;
    int          target;
    logic [2:0]  op;
    limit_plan = '{16'd0, 16'd65535, 16'd1, 16'd248, 16'd512, 16'd0};
    limit_plan[3] = 16'($urandom_range(65535));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, boundary regions, window edges, unknown codes
    send_request(OP_METADATA, 16'h0000, 32'h0, 32'h0);
    send_request(OP_ENTRY, 16'h0000, 32'h0, 32'h0);
    send_request(OP_RDCHECK, 16'h0000, 32'h0, 32'h0);
    add_region(32'h0000_0000, 32'h0000_0000);
    add_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_region(32'h0000_1000, 32'h0000_0100);
    add_region(32'hFFFF_0000, 32'h0001_0000);
    send_request(OP_METADATA, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ENTRY, 16'd0, 32'h0, 32'h0);
    send_request(OP_ENTRY, 16'd1, 32'h0, 32'h0);
    send_request(OP_ENTRY, 16'd3, 32'h0, 32'h0);
    send_request(OP_ENTRY, 16'd4, 32'h0, 32'h0);
    send_request(OP_ENTRY, 16'hFFFF, 32'h0, 32'h0);
    send_request(OP_RDCHECK, 16'd2, 32'h0000_1000, 32'h0000_0100);
    send_request(OP_RDCHECK, 16'd2, 32'h0000_0FFF, 32'h0000_0010);
    send_request(OP_RDCHECK, 16'd2, 32'h0000_1001, 32'h0000_0100);
    send_request(OP_RDCHECK, 16'd2, 32'h0000_1080, 32'h0000_0080);
    send_request(OP_RDCHECK, 16'd0, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_RDCHECK, 16'd1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_RDCHECK, 16'd3, 32'hFFFF_0000, 32'h0001_0000);
    send_request(OP_RDCHECK, 16'd4, 32'h0000_1000, 32'h0000_0010);
    send_request(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    clear_table();
    send_request(OP_METADATA, 16'h0000, 32'h0, 32'h0);

    for (phase = 0; phase < 6; phase++) begin
      // read limit changes only with nothing in flight
      in_valid <= 1'b0;
      wait_drained();
      repeat (12) @(posedge clk);
      write_enable <= 1'b1;
      write_data <= limit_plan[phase];
      @(posedge clk);
      write_enable <= 1'b0;
      quiet = (phase == 3);
      target = sent + 188;
      while (sent < target) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          if (shadow_used < MAX_ENTRIES && $urandom_range(1)) begin
            add_region(pick_address(), pick_size());
          end
          n = $urandom_range(4, 1);
          repeat (n) begin
            if (shadow_used > 0) begin
              probe_window($urandom_range(shadow_used - 1), $urandom_range(3) == 0);
            end
          end
        end else if (pick < 65) begin
          if (shadow_used > 0 && $urandom_range(4) != 0) begin
            k = $urandom_range(shadow_used - 1);
          end else begin
            k = $urandom_range(65535);
          end
          send_request(OP_ENTRY, 16'(k), $urandom, $urandom);
        end else if (pick < 72) begin
          send_request(OP_METADATA, 16'($urandom), $urandom, $urandom);
        end else if (pick < 79) begin
          clear_table();
        end else if (pick < 81) begin
          // fill up, then run into overflow
          while (shadow_used < MAX_ENTRIES) add_region(pick_address(), pick_size());
          repeat (2) add_region(pick_address(), pick_size());
          send_request(OP_METADATA, 16'($urandom), $urandom, $urandom);
        end else begin
          op = 3'($urandom);
          case (op)
            OP_REGISTER: add_region($urandom, $urandom);
            OP_CLEAR: clear_table();
            default: send_request(op, 16'($urandom), $urandom, $urandom);
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS dump_region_table_checker");
    end else begin
      $display("FAIL dump_region_table_checker");
    end
    $finish;
  end

endmodule
